>>> rtl/core/clqr_pkg.sv
// Package for the coordinate line quadric roots unit: widths, status codes, payload types.
package clqr_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_DISC = 2'd1,
    ST_BAD_DIAG = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] diag_a;
    logic signed [DATA_W-1:0] lin_coef;
    logic signed [DATA_W-1:0] const_coef;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] t_low;
    logic signed [DATA_W-1:0] t_high;
    status_t                  status;
  } out_t;

endpackage

>>> rtl/core/coordinate_line_quadric_roots_unit.sv
// Top level of the coordinate line quadric roots unit: fully pipelined quadratic solver.
//
// Solves a*t^2 + 2p*t + q = 0 per item and returns t = (-p -/+ sqrt(p^2 - a*q)) / a.
// Input channel in_valid/in_ready/in_data carries diag_a, lin_coef and const_coef,
// signed fixed point (DATA_W bits, FRAC_W fraction bits). Result channel
// out_valid/out_ready/out_data carries t_low, t_high (truncated toward zero, then
// saturated) and a status code: ok, negative discriminant, or nonpositive diag_a;
// on either error both roots are zero.
// Pipeline: one product stage, one discriminant stage, one integer square root
// stage per root bit, one numerator stage, one restoring divide stage per
// quotient bit for each root lane, and the saturating output register.
// Throughput: one item per cycle while out_ready does not stall the pipeline;
// the sqrt and divide steps each own a stage.
// The whole pipeline advances together; when out_ready is low while a result
// waits, every stage holds and in_ready drops, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers hold junk.
module coordinate_line_quadric_roots_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  clqr_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output clqr_pkg::out_t  out_data
);

  localparam int W  = clqr_pkg::DATA_W;
  localparam int F  = clqr_pkg::FRAC_W;
  localparam int NW = W + 1 + F;   // scaled numerator magnitude width
  localparam int RW = W + 2;       // square root remainder width

  logic en;
  logic out_valid_r;

  // Whole pipeline moves when the output slot is free or being drained.
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  // ---------------- stage 1: split signs, form both products ----------------
  logic             an, pn, qn;
  logic [W-1:0]     amag_in, pmag_in, qmag_in;

  always_comb begin
    an = in_data.diag_a[W-1];
    pn = in_data.lin_coef[W-1];
    qn = in_data.const_coef[W-1];
    amag_in = in_data.diag_a;
    pmag_in = pn ? (~in_data.lin_coef + 1'b1) : in_data.lin_coef;
    qmag_in = qn ? (~in_data.const_coef + 1'b1) : in_data.const_coef;
  end

  logic             v1_r;
  logic [2*W-1:0]   p2_r, aq_r;
  logic             bad1_r, qnz1_r, pn1_r;
  logic [W-1:0]     pmag1_r, amag1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      p2_r    <= pmag_in * pmag_in;
      aq_r    <= amag_in * qmag_in;
      bad1_r  <= an || (in_data.diag_a == '0);
      qnz1_r  <= qn || (in_data.const_coef == '0);
      pn1_r   <= pn;
      pmag1_r <= pmag_in;
      amag1_r <= amag_in;
    end
  end

  // ---------------- stage 2 and square root stages ----------------
  logic                     sq_v_r    [0:W];
  logic [2*W-1:0]           sq_d_r    [0:W];
  logic [RW-1:0]            sq_rem_r  [0:W];
  logic [W-1:0]             sq_root_r [0:W];
  clqr_pkg::status_t        sq_st_r   [0:W];
  logic                     sq_pn_r   [0:W];
  logic [W-1:0]             sq_pmag_r [0:W];
  logic [W-1:0]             sq_a_r    [0:W];

  clqr_pkg::status_t        st2;
  logic [2*W-1:0]           d2;

  always_comb begin
    d2  = '0;
    st2 = clqr_pkg::ST_OK;
    priority if (bad1_r) begin
      st2 = clqr_pkg::ST_BAD_DIAG;
    end else if (qnz1_r) begin
      d2 = p2_r + aq_r;
    end else if (p2_r < aq_r) begin
      st2 = clqr_pkg::ST_NEG_DISC;
    end else begin
      d2 = p2_r - aq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= v1_r;
    end
    if (en) begin
      sq_d_r[0]    <= d2;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_st_r[0]   <= st2;
      sq_pn_r[0]   <= pn1_r;
      sq_pmag_r[0] <= pmag1_r;
      sq_a_r[0]    <= amag1_r;
    end
  end

  // One result bit per stage: bring down two radicand bits, try root*4+1.
  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic [RW+1:0] cand, trial;
    logic          take;

    always_comb begin
      cand  = {sq_rem_r[k], sq_d_r[k][2*W-1 -: 2]};
      trial = {{(RW-W){1'b0}}, sq_root_r[k], 2'b01};
      take  = (cand >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      if (en) begin
        sq_d_r[k+1]    <= {sq_d_r[k][2*W-3:0], 2'b00};
        sq_rem_r[k+1]  <= take ? RW'(cand - trial) : RW'(cand);
        sq_root_r[k+1] <= {sq_root_r[k][W-2:0], take};
        sq_st_r[k+1]   <= sq_st_r[k];
        sq_pn_r[k+1]   <= sq_pn_r[k];
        sq_pmag_r[k+1] <= sq_pmag_r[k];
        sq_a_r[k+1]    <= sq_a_r[k];
      end
    end
  end

  // ---------------- numerator stage and divider lanes ----------------
  logic                     dv_v_r   [0:NW];
  clqr_pkg::status_t        dv_st_r  [0:NW];
  logic [W-1:0]             dv_a_r   [0:NW];
  logic                     lo_neg_r [0:NW];
  logic                     hi_neg_r [0:NW];
  logic [NW-1:0]            lo_n_r   [0:NW];
  logic [NW-1:0]            hi_n_r   [0:NW];
  logic [NW-1:0]            lo_q_r   [0:NW];
  logic [NW-1:0]            hi_q_r   [0:NW];
  logic [W-1:0]             lo_rem_r [0:NW];
  logic [W-1:0]             hi_rem_r [0:NW];

  logic signed [W+1:0]      negp, num_lo, num_hi, sext;
  logic [W:0]               mag_lo, mag_hi;

  always_comb begin
    negp   = sq_pn_r[W] ? $signed({2'b00, sq_pmag_r[W]}) : -$signed({2'b00, sq_pmag_r[W]});
    sext   = $signed({2'b00, sq_root_r[W]});
    num_lo = negp - sext;
    num_hi = negp + sext;
    mag_lo = num_lo[W+1] ? (W+1)'(-num_lo) : num_lo[W:0];
    mag_hi = num_hi[W+1] ? (W+1)'(-num_hi) : num_hi[W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[W];
    end
    if (en) begin
      dv_st_r[0]  <= sq_st_r[W];
      dv_a_r[0]   <= sq_a_r[W];
      lo_neg_r[0] <= num_lo[W+1];
      hi_neg_r[0] <= num_hi[W+1];
      lo_n_r[0]   <= {mag_lo, {F{1'b0}}};
      hi_n_r[0]   <= {mag_hi, {F{1'b0}}};
      lo_q_r[0]   <= '0;
      hi_q_r[0]   <= '0;
      lo_rem_r[0] <= '0;
      hi_rem_r[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage in each lane.
  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [W:0] c_lo, c_hi, dvs;
    logic       t_lo, t_hi;

    always_comb begin
      dvs  = {1'b0, dv_a_r[j]};
      c_lo = {lo_rem_r[j], lo_n_r[j][NW-1]};
      c_hi = {hi_rem_r[j], hi_n_r[j][NW-1]};
      t_lo = (c_lo >= dvs);
      t_hi = (c_hi >= dvs);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      if (en) begin
        dv_st_r[j+1]  <= dv_st_r[j];
        dv_a_r[j+1]   <= dv_a_r[j];
        lo_neg_r[j+1] <= lo_neg_r[j];
        hi_neg_r[j+1] <= hi_neg_r[j];
        lo_n_r[j+1]   <= {lo_n_r[j][NW-2:0], 1'b0};
        hi_n_r[j+1]   <= {hi_n_r[j][NW-2:0], 1'b0};
        lo_q_r[j+1]   <= {lo_q_r[j][NW-2:0], t_lo};
        hi_q_r[j+1]   <= {hi_q_r[j][NW-2:0], t_hi};
        lo_rem_r[j+1] <= t_lo ? W'(c_lo - dvs) : W'(c_lo);
        hi_rem_r[j+1] <= t_hi ? W'(c_hi - dvs) : W'(c_hi);
      end
    end
  end

  // ---------------- saturate, apply sign, zero on error ----------------
  localparam logic [NW-1:0] MAXPOS = NW'({1'b0, {(W-1){1'b1}}});

  logic [NW-1:0] lim_lo, lim_hi, v_lo, v_hi;
  logic [W-1:0]  r_lo, r_hi;
  clqr_pkg::out_t out_nxt;
  clqr_pkg::out_t out_r;

  always_comb begin
    lim_lo = lo_neg_r[NW] ? MAXPOS + 1'b1 : MAXPOS;
    lim_hi = hi_neg_r[NW] ? MAXPOS + 1'b1 : MAXPOS;
    v_lo   = (lo_q_r[NW] > lim_lo) ? lim_lo : lo_q_r[NW];
    v_hi   = (hi_q_r[NW] > lim_hi) ? lim_hi : hi_q_r[NW];
    r_lo   = lo_neg_r[NW] ? W'(-v_lo) : v_lo[W-1:0];
    r_hi   = hi_neg_r[NW] ? W'(-v_hi) : v_hi[W-1:0];
    out_nxt.status = dv_st_r[NW];
    if (dv_st_r[NW] == clqr_pkg::ST_OK) begin
      out_nxt.t_low  = r_lo;
      out_nxt.t_high = r_hi;
    end else begin
      out_nxt.t_low  = '0;
      out_nxt.t_high = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[NW];
    end
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
